@@ src/ssop_pkg.sv @@
// Shared types and constants of the stream sequence operator.
// Used by the front, back and top-level modules; depends on nothing else.
package ssop_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int RESULT_W          = 32;
   localparam int OP_W              = 16;
   localparam int MODE_W            = 3;
   // One bit above the parameter field, so that the delay limit itself can be compared.
   localparam int CMP_W             = OP_W + 1;
   localparam int DELAY_MAX_DEFAULT = 1024;
   localparam int ADDR_W            = 4;
   localparam int DATA_W            = 32;

   localparam logic [MODE_W-1:0] MODE_PAD   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELAY = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UP    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DIFF  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SUM   = 3'd5;

   localparam logic [1:0] REG_MODE = 2'd0;
   localparam logic [1:0] REG_OP   = 2'd1;
   localparam logic [1:0] REG_FILL = 2'd2;

   // The running sum needs a ninth kind, so the kind code is four bits wide.
   typedef enum logic [3:0] {
      K_ERROR,
      K_IDLE,
      K_PAD,
      K_UP,
      K_PASS,
      K_DELAY,
      K_DOWN,
      K_DIFF,
      K_SUM
   } kind_type;

   typedef struct packed {
      kind_type                    kind;
      logic                        has;
      logic signed [SAMPLE_W-1:0]  sample;
   } item_type;

endpackage

@@ src/ssop_front.sv @@
// Front end: accepts requests, classifies them by the current set-up and queues them.
// Depends on ssop_pkg.
module ssop_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_sample_valid,
   input  logic signed [ssop_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [ssop_pkg::MODE_W-1:0]           mode,
   input  logic [ssop_pkg::OP_W-1:0]             op_param,
   output ssop_pkg::item_type                    q_item,
   output logic                                  q_valid,
   input  logic                                  q_ready
);
   import ssop_pkg::*;

   parameter int DELAY_MAX = DELAY_MAX_DEFAULT;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       enabled;
   logic       push, pop;
   item_type   item_new;

   always_comb begin
      case (mode)
         MODE_PAD, MODE_DIFF, MODE_SUM: enabled = 1'b1;
         MODE_DELAY: enabled = CMP_W'(op_param) <= CMP_W'(DELAY_MAX);
         MODE_UP, MODE_DOWN: enabled = op_param != '0;
         default: enabled = 1'b0;
      endcase
   end

   always_comb begin
      item_new.has    = req_sample_valid;
      item_new.sample = req_sample;
      item_new.kind   = K_ERROR;
      if (enabled) begin
         case (mode)
            MODE_PAD:   item_new.kind = K_PAD;
            MODE_UP:    item_new.kind = K_UP;
            MODE_DELAY: item_new.kind = !req_sample_valid ? K_IDLE :
                                        (op_param == '0) ? K_PASS : K_DELAY;
            MODE_DOWN:  item_new.kind = req_sample_valid ? K_DOWN : K_IDLE;
            MODE_DIFF:  item_new.kind = req_sample_valid ? K_DIFF : K_IDLE;
            MODE_SUM:   item_new.kind = req_sample_valid ? K_SUM : K_IDLE;
            default:    item_new.kind = K_ERROR;
         endcase
      end
   end

   assign req_ready = count_ff != 2'd2;
   assign q_valid   = count_ff != 2'd0;
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

@@ src/ssop_back.sv @@
// Back end: holds the operator state and the delay ring, executes one request a cycle while
// the response register is empty or taken, and registers the response. Depends on ssop_pkg.
module ssop_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rearm,
   input  logic                                  rearm_pad,
   input  logic [ssop_pkg::OP_W-1:0]             op_param,
   input  logic signed [ssop_pkg::SAMPLE_W-1:0]  fill_value,
   input  ssop_pkg::item_type                    q_item,
   input  logic                                  q_valid,
   output logic                                  q_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_status,
   output logic                                  rsp_out_valid,
   output logic signed [ssop_pkg::RESULT_W-1:0]  rsp_result
);
   import ssop_pkg::*;

   parameter int DELAY_MAX = DELAY_MAX_DEFAULT;
   localparam int HEAD_W = (DELAY_MAX > 1) ? $clog2(DELAY_MAX) : 1;
   localparam int WARM_W = $clog2(DELAY_MAX + 1);

   logic signed [SAMPLE_W-1:0] store_ff [DELAY_MAX];
   logic signed [SAMPLE_W-1:0] rd_ff;

   logic [OP_W-1:0]            step_ff, step_in;
   logic [HEAD_W-1:0]          head_ff, head_in, head_eff;
   logic [WARM_W-1:0]          warm_ff, warm_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                       seen_ff, seen_in;
   logic signed [RESULT_W-1:0] sum_ff, sum_in;

   logic                       out_full_ff;
   logic                       status_ff, status_in;
   logic                       outv_ff, outv_in;
   logic                       use_mem_ff, use_mem_in;
   logic signed [RESULT_W-1:0] res_ff, res_in;

   logic                       exec, mem_en;
   logic signed [RESULT_W-1:0] x_ext;
   logic [OP_W-1:0]            pos;
   logic [CMP_W-1:0]           pos_inc, head_inc;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [RESULT_W:0]   sum_wide;

   assign q_ready = !out_full_ff || rsp_ready;
   assign exec    = q_valid && q_ready;
   assign x_ext   = RESULT_W'(q_item.sample);

   always_comb begin
      step_in    = step_ff;
      head_in    = head_ff;
      warm_in    = warm_ff;
      prev_in    = prev_ff;
      seen_in    = seen_ff;
      sum_in     = sum_ff;
      status_in  = 1'b0;
      outv_in    = 1'b0;
      use_mem_in = 1'b0;
      res_in     = '0;
      mem_en     = 1'b0;
      pos        = '0;
      pos_inc    = '0;
      head_eff   = '0;
      head_inc   = '0;
      diff       = '0;
      sum_wide   = '0;
      case (q_item.kind)
         K_PAD, K_UP: begin
            if (step_ff != '0) begin
               // A sample offered while zeros are still owed is refused and dropped.
               if (q_item.has) begin
                  status_in = 1'b1;
               end else begin
                  step_in = step_ff - 1'b1;
                  outv_in = 1'b1;
               end
            end else if (q_item.has) begin
               res_in  = x_ext;
               outv_in = 1'b1;
               if (q_item.kind == K_UP && op_param > OP_W'(1)) begin
                  step_in = op_param - 1'b1;
               end
            end
         end
         K_DOWN: begin
            pos     = (step_ff >= op_param) ? '0 : step_ff;
            outv_in = pos == '0;
            res_in  = (pos == '0) ? x_ext : '0;
            pos_inc = CMP_W'(pos) + 1'b1;
            step_in = (pos_inc >= CMP_W'(op_param)) ? '0 : pos_inc[OP_W-1:0];
         end
         K_DIFF: begin
            diff    = (SAMPLE_W+1)'(q_item.sample) - (SAMPLE_W+1)'(prev_ff);
            res_in  = seen_ff ? RESULT_W'(diff) : x_ext;
            prev_in = q_item.sample;
            seen_in = 1'b1;
            outv_in = 1'b1;
         end
         K_SUM: begin
            sum_wide = (RESULT_W+1)'(sum_ff) + (RESULT_W+1)'(q_item.sample);
            if (sum_wide[RESULT_W] != sum_wide[RESULT_W-1]) begin
               sum_in = sum_wide[RESULT_W] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                           : {1'b0, {(RESULT_W-1){1'b1}}};
            end else begin
               sum_in = sum_wide[RESULT_W-1:0];
            end
            res_in  = sum_in;
            outv_in = 1'b1;
         end
         K_DELAY: begin
            head_eff = (CMP_W'(head_ff) >= CMP_W'(op_param)) ? '0 : head_ff;
            mem_en   = 1'b1;
            outv_in  = 1'b1;
            if (CMP_W'(warm_ff) < CMP_W'(op_param)) begin
               res_in  = RESULT_W'(fill_value);
               warm_in = warm_ff + 1'b1;
            end else begin
               // The delayed sample comes from the ring read register, loaded with the response.
               use_mem_in = 1'b1;
            end
            head_inc = CMP_W'(head_eff) + 1'b1;
            head_in  = (head_inc >= CMP_W'(op_param)) ? '0 : head_inc[HEAD_W-1:0];
         end
         K_PASS: begin
            res_in  = x_ext;
            outv_in = 1'b1;
         end
         K_ERROR: begin
            status_in = 1'b1;
         end
         K_IDLE: begin
            status_in = 1'b0;
         end
         default: begin
            status_in = 1'b0;
         end
      endcase
   end

   // The ring reads the old entry and stores the new sample at the same slot in one access.
   always_ff @(posedge clock) begin
      if (exec && mem_en) begin
         store_ff[head_eff] <= q_item.sample;
         rd_ff              <= store_ff[head_eff];
      end
   end

   // Only pad mode starts with zeros owed after a re-arm.
   always_ff @(posedge clock) begin
      if (reset || rearm) begin
         step_ff <= (rearm && rearm_pad) ? op_param : '0;
         head_ff <= '0;
         warm_ff <= '0;
         prev_ff <= '0;
         seen_ff <= 1'b0;
         sum_ff  <= '0;
      end else if (exec) begin
         step_ff <= step_in;
         head_ff <= head_in;
         warm_ff <= warm_in;
         prev_ff <= prev_in;
         seen_ff <= seen_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (exec) begin
         out_full_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff  <= status_in;
         outv_ff    <= outv_in;
         use_mem_ff <= use_mem_in;
         res_ff     <= res_in;
      end
   end

   assign rsp_valid     = out_full_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_valid = outv_ff;
   assign rsp_result    = use_mem_ff ? RESULT_W'(rd_ff) : res_ff;

endmodule

@@ src/stream_sequence_operator.sv @@
// Stream sequence operator: an APB-style register block feeding a front end that
// queues requests and a back end that executes them. Depends on ssop_pkg, ssop_front, ssop_back.
//
// One request is taken per clock cycle, sustained, while the response side does not stall,
// and every request gives exactly one response, registered in the back end; a two-entry queue
// between front and back absorbs stalls on either side. Writing any register (mode at 0x0,
// op_param at 0x4, fill_value at 0x8) re-arms the operator; the user must write registers only
// while no request is in flight, which the block does not enforce. The delay ring holds no
// reset contents and needs no clearing pass.
module stream_sequence_operator #(
   parameter int DELAY_MAX = ssop_pkg::DELAY_MAX_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_sample_valid,
   input  logic signed [ssop_pkg::SAMPLE_W-1:0]  req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_status,
   output logic                                  rsp_out_valid,
   output logic signed [ssop_pkg::RESULT_W-1:0]  rsp_result,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ssop_pkg::ADDR_W-1:0]           paddr,
   input  logic [ssop_pkg::DATA_W-1:0]           pwdata,
   output logic [ssop_pkg::DATA_W-1:0]           prdata,
   output logic                                  pready
);
   import ssop_pkg::*;

   logic [MODE_W-1:0]          mode_ff;
   logic [OP_W-1:0]            op_param_ff;
   logic signed [SAMPLE_W-1:0] fill_ff;
   logic                       rearm_ff;
   logic                       wr_en;
   logic [1:0]                 reg_index;
   item_type                   q_item;
   logic                       q_valid, q_ready;

   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;
   assign reg_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_PAD;
         op_param_ff <= '0;
         fill_ff     <= '0;
         rearm_ff    <= 1'b0;
      end else begin
         rearm_ff <= 1'b0;
         if (wr_en) begin
            case (reg_index)
               REG_MODE: begin
                  mode_ff  <= pwdata[MODE_W-1:0];
                  rearm_ff <= 1'b1;
               end
               REG_OP: begin
                  op_param_ff <= pwdata[OP_W-1:0];
                  rearm_ff    <= 1'b1;
               end
               REG_FILL: begin
                  fill_ff  <= pwdata[SAMPLE_W-1:0];
                  rearm_ff <= 1'b1;
               end
               default: begin
                  rearm_ff <= 1'b0;
               end
            endcase
         end
      end
   end

   always_comb begin
      case (reg_index)
         REG_MODE: prdata = DATA_W'(mode_ff);
         REG_OP:   prdata = DATA_W'(op_param_ff);
         REG_FILL: prdata = DATA_W'($unsigned(fill_ff));
         default:  prdata = '0;
      endcase
   end

   ssop_front #(
      .DELAY_MAX(DELAY_MAX)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_valid (req_sample_valid),
      .req_sample       (req_sample),
      .mode             (mode_ff),
      .op_param         (op_param_ff),
      .q_item           (q_item),
      .q_valid          (q_valid),
      .q_ready          (q_ready)
   );

   ssop_back #(
      .DELAY_MAX(DELAY_MAX)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .rearm         (rearm_ff),
      .rearm_pad     (mode_ff == MODE_PAD),
      .op_param      (op_param_ff),
      .fill_value    (fill_ff),
      .q_item        (q_item),
      .q_valid       (q_valid),
      .q_ready       (q_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_valid (rsp_out_valid),
      .rsp_result    (rsp_result)
   );

endmodule

@@ tb/sv/tb_stream_sequence_operator.sv @@
// Self-checking testbench for stream_sequence_operator: random request and response
// stalls, APB-style set-up between phases and an in-order predictor of every mode.
// Depends on ssop_pkg and the operator RTL only.
`timescale 1ns / 1ps

module tb_stream_sequence_operator;
   import ssop_pkg::*;

   localparam int          DELAY_MAX     = DELAY_MAX_DEFAULT;
   localparam int          RANDOM_TARGET = 800;
   localparam int          LONG_DELAY    = 160;
   localparam longint      TIMEOUT_NS    = 40_000_000;
   localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

   typedef struct {
      logic                       has;
      logic signed [SAMPLE_W-1:0] sample;
   } sample_req_t;

   typedef struct {
      logic                       status;
      logic                       out_valid;
      logic signed [RESULT_W-1:0] result;
   } operator_out_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_sample_valid = 1'b0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_status;
   logic                       rsp_out_valid;
   logic signed [RESULT_W-1:0] rsp_result;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [ADDR_W-1:0]          paddr = '0;
   logic [DATA_W-1:0]          pwdata = '0;
   logic [DATA_W-1:0]          prdata;
   logic                       pready;

   // Shadow of the operator's registers and internal state.
   logic [MODE_W-1:0]          cfg_mode = MODE_PAD;
   logic [OP_W-1:0]            cfg_op = '0;
   logic signed [SAMPLE_W-1:0] cfg_fill = '0;
   logic signed [SAMPLE_W-1:0] delay_ring [DELAY_MAX];
   int unsigned                ring_pos;
   int unsigned                warm_cnt;
   int unsigned                count_left;
   logic signed [SAMPLE_W-1:0] last_x;
   bit                         got_first;
   logic signed [RESULT_W-1:0] acc;
   bit                         active;

   sample_req_t   queued_requests[$];
   operator_out_t predicted_outputs[$];
   int unsigned   queued_count = 0;
   int unsigned   accepted_count = 0;
   int unsigned   checked_count = 0;
   int unsigned   mismatches = 0;
   int unsigned   setting_count = 0;
   int unsigned   send_gap_pct = 0;
   int unsigned   recv_stall_pct = 0;

   stream_sequence_operator DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_valid (req_sample_valid),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_result       (rsp_result),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #4 clock = ~clock;

   function automatic void rearm_operator();
      ring_pos   = 0;
      warm_cnt   = 0;
      count_left = (cfg_mode == MODE_PAD) ? cfg_op : 0;
      last_x     = '0;
      got_first  = 1'b0;
      acc        = '0;
      if (cfg_mode > MODE_SUM) begin
         active = 1'b0;
      end else if (cfg_mode == MODE_DELAY) begin
         active = (cfg_op <= DELAY_MAX);
      end else if (cfg_mode == MODE_UP || cfg_mode == MODE_DOWN) begin
         active = (cfg_op != 0);
      end else begin
         active = 1'b1;
      end
   endfunction

   function automatic operator_out_t step_operator(logic has, logic signed [SAMPLE_W-1:0] x);
      operator_out_t o;
      int            y;
      longint        s;
      o.status    = 1'b0;
      o.out_valid = 1'b0;
      y = 0;
      if (!active) begin
         o.status = 1'b1;
      end else if (cfg_mode == MODE_PAD || cfg_mode == MODE_UP) begin
         if (count_left > 0) begin
            if (has) begin
               o.status = 1'b1;
            end else begin
               count_left--;
               o.out_valid = 1'b1;
            end
         end else if (has) begin
            y = x;
            o.out_valid = 1'b1;
            if (cfg_mode == MODE_UP && cfg_op > 1) count_left = cfg_op - 1;
         end
      end else if (has) begin
         o.out_valid = 1'b1;
         case (cfg_mode)
            MODE_DELAY: begin
               if (cfg_op == 0) begin
                  y = x;
               end else begin
                  if (ring_pos >= cfg_op || ring_pos >= DELAY_MAX) ring_pos = 0;
                  if (warm_cnt < cfg_op) begin
                     y = cfg_fill;
                     warm_cnt++;
                  end else begin
                     y = delay_ring[ring_pos];
                  end
                  delay_ring[ring_pos] = x;
                  ring_pos++;
                  if (ring_pos >= cfg_op) ring_pos = 0;
               end
            end
            MODE_DOWN: begin
               if (count_left >= cfg_op) count_left = 0;
               if (count_left == 0) y = x;
               else o.out_valid = 1'b0;
               count_left++;
               if (count_left >= cfg_op) count_left = 0;
            end
            MODE_DIFF: begin
               y = got_first ? int'(x) - int'(last_x) : int'(x);
               last_x    = x;
               got_first = 1'b1;
            end
            default: begin
               s = longint'(acc) + longint'(x);
               if (s > 64'sd2147483647) s = 64'sd2147483647;
               if (s < -64'sd2147483648) s = -64'sd2147483648;
               acc = s[31:0];
               y   = acc;
            end
         endcase
      end
      if (!o.out_valid) y = 0;
      o.result = y;
      return o;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(7, 0))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_extreme_param();
      case ($urandom_range(6, 0))
         0:       return OP_W'(0);
         1:       return OP_W'(1);
         2:       return OP_W'(2);
         3:       return OP_W'(DELAY_MAX - 1);
         4:       return OP_W'(DELAY_MAX);
         5:       return OP_W'(DELAY_MAX + 1);
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input operator_out_t want,
                                  input operator_out_t got);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] %s: expected status %0b valid %0b result %0d, got %0b %0b %0d",
                  $realtime, what, want.status, want.out_valid, want.result,
                  got.status, got.out_valid, got.result);
   endtask

   // Request driver; a request leaves the queue only when the channel is free.
   always @(posedge clock) begin : drive_requests
      sample_req_t next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_outputs.push_back(step_operator(req_sample_valid, req_sample));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (queued_requests.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
               next_req = queued_requests.pop_front();
               req_valid        <= 1'b1;
               req_sample_valid <= next_req.has;
               req_sample       <= next_req.sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      operator_out_t want;
      operator_out_t got;
      rsp_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         got.status    = rsp_status;
         got.out_valid = rsp_out_valid;
         got.result    = rsp_result;
         if (predicted_outputs.size() == 0) begin
            want = '{1'bx, 1'bx, 'x};
            report_mismatch("response with no request outstanding", want, got);
         end else begin
            want = predicted_outputs.pop_front();
            checked_count++;
            if (got.status !== want.status || got.out_valid !== want.out_valid ||
                got.result !== want.result)
               report_mismatch("response mismatch", want, got);
         end
      end
   end

   task automatic push_request(input logic has, input logic signed [SAMPLE_W-1:0] x);
      sample_req_t r;
      r.has    = has;
      r.sample = x;
      queued_requests.push_back(r);
      queued_count++;
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || predicted_outputs.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_MODE: cfg_mode = value[MODE_W-1:0];
         REG_OP:   cfg_op   = value[OP_W-1:0];
         default:  cfg_fill = value[SAMPLE_W-1:0];
      endcase
      rearm_operator();
   endtask

   // Every register is rewritten, in a rotating order, once the operator has drained.
   task automatic set_operator(input logic [MODE_W-1:0] m, input logic [OP_W-1:0] op,
                               input logic signed [SAMPLE_W-1:0] fill);
      int unsigned first;
      first = $urandom_range(2, 0);
      wait_idle();
      for (int k = 0; k < 3; k++) begin
         case ((first + k) % 3)
            0:       write_register(REG_MODE, {{(DATA_W-MODE_W){1'b0}}, m});
            1:       write_register(REG_OP, {{(DATA_W-OP_W){1'b0}}, op});
            default: write_register(REG_FILL, {{(DATA_W-SAMPLE_W){fill[SAMPLE_W-1]}}, fill});
         endcase
      end
      setting_count++;
   endtask

   // Mostly well-formed streams for the mode, with a little noise mixed in.
   task automatic gen_stream(input logic [MODE_W-1:0] m, input int unsigned op,
                             input int n, output int counted);
      logic has;
      counted = 0;
      case (m)
         MODE_PAD: begin
            for (int unsigned k = 0; k < op && counted < n; k++) begin
               push_request($urandom_range(9, 0) == 0, rand_sample());
               counted++;
            end
            while (counted < n) begin
               push_request($urandom_range(3, 0) != 0, rand_sample());
               counted++;
            end
         end
         MODE_UP: begin
            while (counted < n) begin
               push_request(1'b1, rand_sample());
               counted++;
               for (int unsigned k = 1; k < op && counted < n; k++) begin
                  push_request($urandom_range(9, 0) == 0, rand_sample());
                  counted++;
               end
               if ($urandom_range(4, 0) == 0) begin
                  push_request(1'b0, rand_sample());
                  counted++;
               end
            end
         end
         MODE_DELAY, MODE_DOWN, MODE_DIFF, MODE_SUM: begin
            while (counted < n) begin
               has = ($urandom_range(99, 0) >= 15);
               push_request(has, rand_sample());
               if (has) counted++;
            end
         end
         default: begin
            repeat (n) push_request(1'($urandom_range(1, 0)), rand_sample());
            counted = n;
         end
      endcase
   endtask

   task automatic run_phase(input logic [MODE_W-1:0] m, input logic [OP_W-1:0] op,
                            input logic signed [SAMPLE_W-1:0] fill, input int n,
                            output int counted);
      set_operator(m, op, fill);
      gen_stream(m, op, n, counted);
   endtask

   task automatic set_idling(input int stage);
      case (stage)
         0: begin
            send_gap_pct   = 16;
            recv_stall_pct = 68;
         end
         1: begin
            send_gap_pct   = 68;
            recv_stall_pct = 16;
         end
         default: begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   initial begin : stimulus
      int                         counted;
      int                         random_total;
      int                         stage;
      bit                         long_delay_done;
      logic [MODE_W-1:0]          m;
      logic [OP_W-1:0]            op;
      logic signed [SAMPLE_W-1:0] fill;
      random_total    = 0;
      long_delay_done = 1'b0;
      rearm_operator();
      set_idling(0);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset set-up: padding with no zeros, so samples pass straight through.
      push_request(1'b1, 16'sh7FFF);
      push_request(1'b0, 16'sh5555);
      push_request(1'b1, 16'sh8000);
      // Samples offered while zeros are still pending are refused.
      set_operator(MODE_PAD, OP_W'(2), '0);
      push_request(1'b1, 16'sh1111);
      push_request(1'b0, 16'sh0000);
      push_request(1'b0, 16'shFFFF);
      push_request(1'b1, 16'shFFFF);
      push_request(1'b0, 16'sh2222);
      // Zero delay passes through; a short delay shows the fill value first.
      set_operator(MODE_DELAY, '0, 16'sh8000);
      push_request(1'b1, 16'sh1234);
      push_request(1'b0, 16'sh4321);
      set_operator(MODE_DELAY, OP_W'(2), 16'sh7FFF);
      push_request(1'b1, 16'sh0001);
      push_request(1'b1, 16'sh8000);
      push_request(1'b1, 16'sh7FFF);
      push_request(1'b1, 16'shFFFF);
      set_operator(MODE_UP, OP_W'(3), '0);
      push_request(1'b1, 16'sh7FFF);
      push_request(1'b0, 16'sh0000);
      push_request(1'b1, 16'sh0F0F);
      push_request(1'b0, 16'sh0000);
      push_request(1'b0, 16'sh0000);
      // A factor of zero and a reserved mode both leave the operator inactive.
      set_operator(MODE_DOWN, '0, '0);
      push_request(1'b1, 16'sh0101);
      set_operator(MODE_RSVD6, OP_W'(5), 16'sh1000);
      push_request(1'b1, 16'sh0202);
      push_request(1'b0, 16'sh0303);
      set_operator(MODE_DIFF, '0, '0);
      push_request(1'b1, 16'sh7FFF);
      push_request(1'b1, 16'sh8000);
      set_operator(MODE_SUM, '0, '0);
      push_request(1'b1, 16'shFFFF);

      // Largest parameter values, kept to a handful of requests each.
      run_phase(MODE_PAD, 16'hFFFF, 16'sh7FFF, 8, counted);
      run_phase(MODE_UP, 16'hFFFF, 16'sh8000, 8, counted);
      run_phase(MODE_DOWN, 16'hFFFF, 16'sh0000, 8, counted);
      run_phase(MODE_DELAY, OP_W'(DELAY_MAX + 1), 16'sh7FFF, 4, counted);
      run_phase(MODE_RSVD7, 16'hFFFF, 16'sh8000, 4, counted);

      while (random_total < RANDOM_TARGET) begin
         stage = (random_total * 3) / RANDOM_TARGET;
         set_idling(stage);
         if (stage == 1 && !long_delay_done) begin
            // A long ring, run well past its wrap point.
            run_phase(MODE_DELAY, OP_W'(LONG_DELAY), rand_sample(), LONG_DELAY + 40,
                      counted);
            long_delay_done = 1'b1;
         end
         m = ($urandom_range(19, 0) < 18) ? MODE_W'($urandom_range(5, 0))
                                          : MODE_W'($urandom_range(7, 6));
         case ($urandom_range(9, 0))
            0:       op = pick_extreme_param();
            1:       op = OP_W'($urandom);
            default: op = OP_W'($urandom_range((m == MODE_DELAY) ? 48 : 9, 0));
         endcase
         fill = ($urandom_range(3, 0) == 0) ? (($urandom_range(1, 0) == 0) ? 16'sh7FFF
                                                                         : 16'sh8000)
                                             : rand_sample();
         run_phase(m, op, fill, $urandom_range(60, 20), counted);
         random_total += counted;
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Run summary: %0d requests over %0d operator settings, %0d responses checked.",
               accepted_count, setting_count, checked_count);
      $display("Mismatching or unexpected responses: %0d, still outstanding: %0d.",
               mismatches, predicted_outputs.size());
      if (mismatches == 0 && predicted_outputs.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #TIMEOUT_NS;
      $display("Timed out with %0d requests queued and %0d responses outstanding.",
               queued_requests.size(), predicted_outputs.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ sim.f @@
src/ssop_pkg.sv
src/ssop_front.sv
src/ssop_back.sv
src/stream_sequence_operator.sv
tb/sv/tb_stream_sequence_operator.sv
